// ----- design/utf8v_pkg.sv -----
`timescale 1ns / 1ps

package utf8v_pkg;

	// Zero byte ends a string.
	localparam logic [7:0] BYTE_NUL = 8'h00;

	// Printable ASCII range and the control characters accepted in text.
	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7E;
	localparam logic [7:0] CH_BEL   = 8'h07;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ESC   = 8'h1B;

	// Continuation bytes a lead byte calls for; zero means not a lead byte.
	localparam logic [2:0] LEAD_NONE = 3'd0;

	typedef struct packed {
		logic       zero;      // terminator
		logic       ascii;     // top bit clear
		logic       ascii_ok;  // printable or allowed control
		logic       cont;      // 10xxxxxx
		logic [2:0] lead_len;  // continuations a lead byte opens
	} utf8v_class_t;

endpackage

// ----- design/utf8v_if.sv -----
`timescale 1ns / 1ps

interface utf8v_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface utf8v_flag_if;
	logic valid;
	logic ready;
	logic is_utf8;

	modport source (output valid, output is_utf8, input ready);
	modport sink   (input valid, input is_utf8, output ready);
endinterface

// ----- design/utf8v_classify.sv -----
`timescale 1ns / 1ps

module utf8v_classify
	import utf8v_pkg::*;
(
	input  logic [7:0]   data_byte,
	output utf8v_class_t cls
);

	always_comb begin
		cls.zero     = (data_byte == BYTE_NUL);
		cls.ascii    = ~data_byte[7];
		cls.cont     = (data_byte[7:6] == 2'b10);
		cls.ascii_ok = ~data_byte[7] && (data_byte inside {[PRINT_LO:PRINT_HI], CH_BEL, CH_BS,
			CH_HT, CH_LF, CH_FF, CH_CR, CH_ESC});
		casez (data_byte)
			8'b110?_????: cls.lead_len = 3'd1;
			8'b1110_????: cls.lead_len = 3'd2;
			8'b1111_0???: cls.lead_len = 3'd3;
			8'b1111_10??: cls.lead_len = 3'd4;
			8'b1111_110?: cls.lead_len = 3'd5;
			default:      cls.lead_len = LEAD_NONE;
		endcase
	end

endmodule

// ----- design/utf8v_track.sv -----
`timescale 1ns / 1ps

module utf8v_track
	import utf8v_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         advance,
	input  utf8v_class_t cls,
	output logic         verdict
);

	logic [2:0] pend_q, pend_d;
	logic       seen_q, seen_d;
	logic       failed_q, failed_d;

	assign verdict = ~failed_q & seen_q;

	always_comb begin
		pend_d   = pend_q;
		seen_d   = seen_q;
		failed_d = failed_q;
		if (advance) begin
			if (cls.zero) begin
				pend_d   = '0;
				seen_d   = 1'b0;
				failed_d = 1'b0;
			end else if (failed_q) begin
				// hold until the terminator
			end else if (pend_q != 3'd0) begin
				if (cls.cont) begin
					pend_d = pend_q - 3'd1;
					if (pend_q == 3'd1) begin
						seen_d = 1'b1;
					end
				end else begin
					failed_d = 1'b1;
					pend_d   = '0;
				end
			end else if (cls.ascii) begin
				if (!cls.ascii_ok) begin
					failed_d = 1'b1;
				end
			end else if (cls.lead_len != LEAD_NONE) begin
				pend_d = cls.lead_len;
			end else begin
				failed_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			seen_q   <= 1'b0;
			failed_q <= 1'b0;
		end else begin
			pend_q   <= pend_d;
			seen_q   <= seen_d;
			failed_q <= failed_d;
		end
	end

endmodule

// ----- design/utf8_text_validator.sv -----
`timescale 1ns / 1ps
// Throughput: one byte per cycle, sustained, as long as verdicts are taken.
// A terminating zero byte reaches the output as a verdict through the input
// register, then the result register, where it waits until the sink takes it.
// Only the zero byte yields a result beat; other bytes just update the state.
// Reset (arst_n low, asynchronous) empties both registers and clears the
// per-string state, as if a fresh string were starting.

module utf8_text_validator
	import utf8v_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	utf8v_byte_if.sink        text,
	utf8v_flag_if.source      verdict
);

	// Input stage: one byte waiting for classification.
	logic [7:0]   data_s1;
	logic         valid_s1;

	// Result register.
	logic         is_utf8_q;
	logic         out_valid_q;

	utf8v_class_t cls;
	logic         advance;
	logic         result;

	utf8v_classify u_classify (
		.data_byte (data_s1),
		.cls       (cls)
	);

	// Advance the input stage unless it holds a terminator and the result
	// register is still full and stalled. Nonzero bytes never wait on the sink.
	assign advance = valid_s1 && (!cls.zero || !out_valid_q || verdict.ready);

	utf8v_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cls     (cls),
		.verdict (result)
	);

	// Take a new beat whenever the input stage is empty or moves on.
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			data_s1 <= text.data_byte;
		end
	end

	// Load a verdict on the terminator; drop it once the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && cls.zero) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cls.zero) begin
			is_utf8_q <= result;
		end
	end

	assign verdict.valid   = out_valid_q;
	assign verdict.is_utf8 = is_utf8_q;

endmodule

// ----- design/utf8v_checker.sv -----
`timescale 1ns / 1ps

module utf8v_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_flag
);

	logic       zero_beat;
	logic       out_beat;
	logic [1:0] owed_q;

	assign zero_beat = in_valid && in_ready && (in_byte == 8'h00);
	assign out_beat  = out_valid && out_ready;

	// Track terminators taken in but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= 2'd0;
		end else if (zero_beat && !out_beat) begin
			owed_q <= owed_q + 2'd1;
		end else if (!zero_beat && out_beat) begin
			owed_q <= owed_q - 2'd1;
		end
	end

	a_hold_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_flag))
		else $error("verdict changed while stalled");

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_verdict_owed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> owed_q != 2'd0)
		else $error("verdict without terminator");

	a_owed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		owed_q != 2'd3)
		else $error("too many terminators in flight");

endmodule

bind utf8_text_validator utf8v_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (text.valid),
	.in_ready  (text.ready),
	.in_byte   (text.data_byte),
	.out_valid (verdict.valid),
	.out_ready (verdict.ready),
	.out_flag  (verdict.is_utf8)
);

// ----- dv/utf8_text_validator_test.sv -----
`timescale 1ns / 1ps

module utf8_text_validator_test;
	import utf8v_pkg::*;

	// Longest stretch with no beat on either side before the run is called hung.
	// Real gaps stay well under this limit, which leaves a wide margin.
	localparam int unsigned IDLE_LIMIT = 1000;
	// Cycles to keep watching after the last verdict.
	localparam int unsigned TAIL_CYCLES = 8;
	// Random part stops once this many bytes are queued beyond the directed ones.
	localparam int unsigned RANDOM_BYTES = 1950;
	// Insert a drain pause about this often in the random bytes.
	localparam int unsigned DRAIN_EVERY = 600;

	// Ways to break an otherwise clean string.
	typedef enum int unsigned {
		FLAW_CTRL,   // control byte outside the allowed set, or DEL
		FLAW_STRAY,  // continuation byte with no lead
		FLAW_FE_FF,  // lead byte with no sequence length
		FLAW_CUT,    // sequence cut short by a non-continuation or the terminator
		FLAW_ANY     // any nonzero byte; may turn out harmless
	} flaw_t;

	// One entry of the send queue: a byte, or a request to drain the verdicts.
	typedef struct {
		bit         drain;
		logic [7:0] value;
	} text_entry_t;

	logic clk;
	logic arst_n = 1'b1;

	utf8v_byte_if text_if();
	utf8v_flag_if verdict_if();

	utf8_text_validator u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_if),
		.verdict (verdict_if)
	);

	logic [7:0] ctrl_ok [7] = '{CH_BEL, CH_BS, CH_HT, CH_LF, CH_FF, CH_CR, CH_ESC};

	text_entry_t outgoing_bytes [$];
	bit          expected_verdicts [$];

	// Per-string state of the predictor.
	logic [2:0] open_conts;
	bit         got_multibyte;
	bit         string_failed;

	bit          calm_stretch = 1'b0;
	int unsigned queued_bytes = 0;
	int unsigned queued_strings = 0;
	int unsigned bytes_taken = 0;
	int unsigned verdicts_true = 0;
	int unsigned verdicts_false = 0;
	int unsigned drains_done = 0;
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Text bytes: printable range or one of the accepted control characters.
	function automatic bit text_byte_ok(input logic [7:0] b);
		if (b >= PRINT_LO && b <= PRINT_HI)
			return 1'b1;
		foreach (ctrl_ok[i])
			if (b == ctrl_ok[i])
				return 1'b1;
		return 1'b0;
	endfunction

	// Mostly short gaps, a few long ones, none at all during a calm stretch.
	function automatic int unsigned idle_length();
		int unsigned roll;
		if (calm_stretch)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advance the per-string state by one accepted byte; queue a verdict on NUL.
	task automatic track_text_byte(input logic [7:0] b);
		if (b == BYTE_NUL) begin
			expected_verdicts.push_back(!string_failed && got_multibyte);
			open_conts = LEAD_NONE;
			got_multibyte = 1'b0;
			string_failed = 1'b0;
		end else if (string_failed) begin
			// hold everything until the terminator
		end else if (open_conts != LEAD_NONE) begin
			// Only the 10xxxxxx shape matters inside a sequence.
			if (b[7:6] == 2'b10) begin
				open_conts = open_conts - 3'd1;
				if (open_conts == LEAD_NONE)
					got_multibyte = 1'b1;
			end else begin
				string_failed = 1'b1;
				open_conts = LEAD_NONE;
			end
		end else begin
			casez (b)
				8'b0???_????: string_failed = !text_byte_ok(b);
				8'b110?_????: open_conts = 3'd1;
				8'b1110_????: open_conts = 3'd2;
				8'b1111_0???: open_conts = 3'd3;
				8'b1111_10??: open_conts = 3'd4;
				8'b1111_110?: open_conts = 3'd5;
				// stray continuation, 0xFE and 0xFF
				default:      string_failed = 1'b1;
			endcase
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		text_entry_t e;
		e.drain = 1'b0;
		e.value = b;
		outgoing_bytes.push_back(e);
		queued_bytes++;
		if (b == BYTE_NUL)
			queued_strings++;
	endtask

	task automatic push_drain();
		text_entry_t e;
		e.drain = 1'b1;
		e.value = BYTE_NUL;
		outgoing_bytes.push_back(e);
	endtask

	task automatic add_text_char();
		if ($urandom_range(0, 5) == 0)
			push_byte(ctrl_ok[$urandom_range(0, 6)]);
		else
			push_byte(8'($urandom_range(PRINT_LO, PRINT_HI)));
	endtask

	// Lead byte for a sequence of conts continuations, then kept of them.
	task automatic add_sequence(input int unsigned conts, input int unsigned kept);
		logic [7:0] lead;
		lead = 8'((8'hFF << (7 - conts)) | ($urandom & (8'hFF >> (conts + 2))));
		push_byte(lead);
		repeat (kept)
			push_byte(8'h80 | 8'($urandom_range(0, 63)));
	endtask

	task automatic add_flaw();
		flaw_t      kind;
		logic [7:0] b;
		int unsigned conts;
		kind = flaw_t'($urandom_range(0, 4));
		case (kind)
			FLAW_CTRL: begin
				if ($urandom_range(0, 4) == 0) begin
					push_byte(8'h7F);
				end else begin
					do
						b = 8'($urandom_range(1, 31));
					while (text_byte_ok(b));
					push_byte(b);
				end
			end
			FLAW_STRAY: push_byte(8'h80 | 8'($urandom_range(0, 63)));
			FLAW_FE_FF: push_byte($urandom_range(0, 1) ? 8'hFF : 8'hFE);
			FLAW_CUT: begin
				conts = $urandom_range(1, 5);
				add_sequence(conts, $urandom_range(0, conts - 1));
			end
			default: push_byte(8'($urandom_range(1, 255)));
		endcase
	endtask

	// One random string: mostly clean mixes of text and sequences, some broken.
	task automatic add_string();
		int unsigned tokens;
		int unsigned flaw_at;
		bit          clean;
		int unsigned conts;
		tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
		clean = $urandom_range(0, 99) < 70;
		flaw_at = $urandom_range(0, tokens);
		for (int t = 0; t <= tokens; t++) begin
			// A cut sequence as the last token ends the string mid-sequence.
			if (!clean && t == flaw_at)
				add_flaw();
			if (t < tokens) begin
				if ($urandom_range(0, 1)) begin
					conts = $urandom_range(1, 5);
					add_sequence(conts, conts);
				end else begin
					add_text_char();
				end
			end
		end
		push_byte(BYTE_NUL);
	endtask

	// Stimulus and end of run.
	initial begin
		logic [7:0] directed [24];
		int unsigned next_drain;

		directed = '{
			BYTE_NUL,                                       // empty string
			8'h41, 8'hC2, 8'hBF, BYTE_NUL,                  // text plus two-byte form
			8'hFD, 8'hBF, 8'h80, 8'h80, 8'h80, 8'h80, 8'h7E, BYTE_NUL, // six-byte form
			8'hFF, BYTE_NUL,                                // no sequence length
			8'h80, BYTE_NUL,                                // stray continuation
			8'hE1, 8'h80, 8'h41, BYTE_NUL,                  // text where continuation due
			8'hF0, 8'h80, BYTE_NUL                          // terminator mid-sequence
		};
		foreach (directed[i])
			push_byte(directed[i]);
		push_drain();
		next_drain = queued_bytes + DRAIN_EVERY;
		while (queued_bytes < RANDOM_BYTES + 24) begin
			add_string();
			if (queued_bytes >= next_drain) begin
				push_drain();
				next_drain = queued_bytes + DRAIN_EVERY;
			end
		end

		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Let the sender empty its queue, then let every verdict come home.
		while (outgoing_bytes.size() != 0 || text_if.valid)
			@(posedge clk);
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d bytes in %0d strings, %0d drain pauses",
			bytes_taken, queued_strings, drains_done);
		$display("verdicts checked: %0d true, %0d false, %0d mismatches",
			verdicts_true, verdicts_false, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Flip between idling and back-to-back traffic now and then.
	always @(posedge clk)
		if ($urandom_range(0, 249) == 0)
			calm_stretch <= !calm_stretch;

	// Byte driver: hold a beat until taken, then idle a while or send the next.
	always @(posedge clk or negedge arst_n) begin : feed_text
		int unsigned tx_gap;
		int unsigned drain_quiet;
		bit          launch;
		if (!arst_n) begin
			text_if.valid <= 1'b0;
			text_if.data_byte <= BYTE_NUL;
			tx_gap = 0;
			drain_quiet = 0;
		end else if (!text_if.valid || text_if.ready) begin
			launch = 1'b0;
			if (tx_gap != 0) begin
				tx_gap--;
			end else if (outgoing_bytes.size() != 0) begin
				if (outgoing_bytes[0].drain) begin
					// Wait out a run of quiet checks with no verdict owed, so a NUL taken this edge is counted too.
					drain_quiet = (expected_verdicts.size() == 0) ? drain_quiet + 1 : 0;
					if (drain_quiet == 4) begin
						void'(outgoing_bytes.pop_front());
						drain_quiet = 0;
						drains_done++;
					end
				end else begin
					text_if.data_byte <= outgoing_bytes[0].value;
					void'(outgoing_bytes.pop_front());
					launch = 1'b1;
					tx_gap = idle_length();
				end
			end
			text_if.valid <= launch;
		end
	end

	// Verdict receiver: stall at random, independent of the byte side.
	always @(posedge clk or negedge arst_n) begin : take_verdicts
		int unsigned rx_stall;
		int unsigned pause;
		if (!arst_n) begin
			verdict_if.ready <= 1'b0;
			rx_stall = 0;
		end else if (rx_stall != 0) begin
			verdict_if.ready <= 1'b0;
			rx_stall--;
		end else begin
			pause = idle_length();
			verdict_if.ready <= (pause == 0);
			rx_stall = (pause == 0) ? 0 : pause - 1;
		end
	end

	// Monitor: predict from accepted bytes first, then check the verdict beat,
	// so a verdict taken on the same edge as its NUL still finds its entry.
	always @(posedge clk or negedge arst_n) begin : check_verdicts
		bit want;
		if (!arst_n) begin
			open_conts = LEAD_NONE;
			got_multibyte = 1'b0;
			string_failed = 1'b0;
		end else begin
			if (text_if.valid && text_if.ready) begin
				track_text_byte(text_if.data_byte);
				bytes_taken++;
			end
			if (verdict_if.valid && verdict_if.ready) begin
				if (verdict_if.is_utf8 === 1'b1)
					verdicts_true++;
				else
					verdicts_false++;
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected verdict beat, expected none, got is_utf8=%b",
						$time, verdict_if.is_utf8);
				end else begin
					want = expected_verdicts.pop_front();
					if (verdict_if.is_utf8 !== want) begin
						mismatches++;
						$display("%0t: is_utf8 mismatch, expected %b, got %b",
							$time, want, verdict_if.is_utf8);
					end
				end
			end
		end
	end

	// Watchdog: end the run when neither side moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_if.valid && text_if.ready) || (verdict_if.valid && verdict_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d verdicts outstanding",
					$time, IDLE_LIMIT, expected_verdicts.size());
				$display("status: fail");
				$finish;
			end
		end
	end

endmodule
